>>> hdl/piecewise_linear_interpolator_top_macros.svh
// Assertion macros for the piecewise linear interpolator checker.
// The clock and reset come from clk_i and rst_ni in the scope that uses them.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_TOP_MACROS_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLI_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pli checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define PLI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pli checker: next-cycle property failed");

`endif

>>> hdl/pli_pkg.sv
// Shared types and constants of the piecewise linear interpolator.
// Used by pli_muldiv, the top level and the checker; depends on nothing.
`timescale 1ns / 1ps

package pli_pkg;

  localparam int unsigned MAX_POINTS_DEF = 16;
  localparam int unsigned APB_AW         = 4;

  // Iterations of the shift-add multiply and of the restoring divide.
  localparam int unsigned MD_STEPS = 33;
  localparam logic [32:0] QCAP     = 33'h1_FFFF_FFFF;

  localparam logic [1:0] REG_POINT_COUNT = 2'd0;
  localparam logic [1:0] REG_LEFT_MODE   = 2'd1;
  localparam logic [1:0] REG_RIGHT_MODE  = 2'd2;

  localparam logic [1:0] MODE_EXTEND   = 2'd0;
  localparam logic [1:0] MODE_CLAMP    = 2'd1;
  localparam logic [1:0] MODE_IDENTITY = 2'd2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  typedef struct packed {
    logic               command;
    logic [3:0]         point_index;
    logic signed [31:0] point_in;
    logic signed [31:0] point_out;
    logic signed [31:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic [3:0]         segment;
    logic               zero_width_fault;
  } out_item_t;

  typedef struct packed {
    logic               start;
    logic signed [32:0] num;
    logic signed [32:0] dy;
    logic signed [32:0] den;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [32:0] quot;
  } md_rsp_t;

endpackage

>>> hdl/pli_muldiv.sv
// Iterative |num*dy| / |den| with round-to-nearest and a cap, on one shared adder.
// Depends on pli_pkg for the request and response structs and the step count.
`timescale 1ns / 1ps

module pli_muldiv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pli_pkg::md_req_t  req_i,
  output pli_pkg::md_rsp_t  rsp_o
);

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_MUL  = 3'd1;
  localparam logic [2:0] U_OVF  = 3'd2;
  localparam logic [2:0] U_DIV  = 3'd3;
  localparam logic [2:0] U_RND  = 3'd4;
  localparam logic [2:0] U_INC  = 3'd5;
  localparam logic [2:0] U_DONE = 3'd6;

  localparam logic [5:0] LastStep = 6'(pli_pkg::MD_STEPS - 1);

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : v;
  endfunction

  logic [2:0]  state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] a_q, a_d;
  logic [32:0] d_q, d_d;
  logic [32:0] ph_q, ph_d;
  logic [32:0] pl_q, pl_d;
  logic        rnd_q, rnd_d;

  logic [34:0] alu_a, alu_b, alu_sum;
  logic        alu_sub;
  logic        ge;

  assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + {34'b0, alu_sub};
  assign ge      = ~alu_sum[34];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    a_d     = a_q;
    d_d     = d_q;
    ph_d    = ph_q;
    pl_d    = pl_q;
    rnd_d   = rnd_q;
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      U_IDLE: begin
        if (req_i.start) begin
          a_d     = mag33(req_i.num);
          pl_d    = mag33(req_i.dy);
          d_d     = mag33(req_i.den);
          ph_d    = '0;
          cnt_d   = '0;
          state_d = U_MUL;
        end
      end
      U_MUL: begin
        alu_a = {2'b0, ph_q};
        alu_b = pl_q[0] ? {2'b0, a_q} : '0;
        ph_d  = alu_sum[33:1];
        pl_d  = {alu_sum[0], pl_q[32:1]};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == LastStep) begin
          state_d = U_OVF;
        end
      end
      U_OVF: begin
        // A high half at or above the divisor means the quotient exceeds the cap.
        alu_a   = {2'b0, ph_q};
        alu_b   = {2'b0, d_q};
        alu_sub = 1'b1;
        if (ge) begin
          pl_d    = pli_pkg::QCAP;
          state_d = U_DONE;
        end else begin
          cnt_d   = '0;
          state_d = U_DIV;
        end
      end
      U_DIV: begin
        alu_a   = {1'b0, ph_q, pl_q[32]};
        alu_b   = {2'b0, d_q};
        alu_sub = 1'b1;
        ph_d    = ge ? alu_sum[32:0] : {ph_q[31:0], pl_q[32]};
        pl_d    = {pl_q[31:0], ge};
        cnt_d   = cnt_q + 6'd1;
        if (cnt_q == LastStep) begin
          state_d = U_RND;
        end
      end
      U_RND: begin
        // Round up when twice the remainder reaches the divisor.
        alu_a   = {1'b0, ph_q, 1'b0};
        alu_b   = {2'b0, d_q};
        alu_sub = 1'b1;
        rnd_d   = ge;
        state_d = U_INC;
      end
      U_INC: begin
        alu_a   = {2'b0, pl_q};
        alu_b   = {34'b0, rnd_q};
        pl_d    = alu_sum[33] ? pli_pkg::QCAP : alu_sum[32:0];
        state_d = U_DONE;
      end
      U_DONE: begin
        state_d = U_IDLE;
      end
      default: begin
        state_d = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    a_q   <= a_d;
    d_q   <= d_d;
    ph_q  <= ph_d;
    pl_q  <= pl_d;
    rnd_q <= rnd_d;
  end

  assign rsp_o.done = (state_q == U_DONE);
  assign rsp_o.quot = pl_q;

endmodule

>>> hdl/piecewise_linear_interpolator_top.sv
// Load: the table entry is written and the next transaction is taken in the following cycle.
// Evaluate: a search over the table, then the segment fetch, the range checks and the 33-step
// multiply and 33-step divide on the shared adder in pli_muldiv, up to the result register.
// One evaluate is in flight at a time; the input stalls until its result is registered.
// Reset (rst_ni, async, active low) clears the sequencer, the output valid and the registers
// to point_count 2, both modes extend; the breakpoint table keeps no reset value.
`timescale 1ns / 1ps

// Depends on pli_pkg and instantiates pli_muldiv.
module piecewise_linear_interpolator_top #(
  parameter int unsigned MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  pli_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output pli_pkg::out_item_t           out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pli_pkg::APB_AW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  // Table address width, and a count width that holds both MAX_POINTS and the
  // raw five-bit point_count register.
  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = (AW + 1 > 5) ? AW + 1 : 5;
  localparam logic [CW-1:0] CntMax = CW'(MAX_POINTS);
  localparam logic [CW-1:0] CntMin = CW'(2);

  localparam logic signed [34:0] SumMax = 35'sd2147483647;
  localparam logic signed [34:0] SumMin = -35'sd2147483648;

  // Sequencer states. The search walks the table one entry a cycle, then the
  // lower endpoint is fetched, the two range checks run one after the other,
  // and the scaled quotient comes from the shared multiply/divide unit.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRCH  = 4'd1;
  localparam logic [3:0] S_RDLO  = 4'd2;
  localparam logic [3:0] S_LEFT  = 4'd3;
  localparam logic [3:0] S_RIGHT = 4'd4;
  localparam logic [3:0] S_DIFF  = 4'd5;
  localparam logic [3:0] S_START = 4'd6;
  localparam logic [3:0] S_MD    = 4'd7;
  localparam logic [3:0] S_SUM   = 4'd8;
  localparam logic [3:0] S_SAT   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes complete in the APB access phase; pready
  // is tied high so no wait states are ever inserted.
  // ---------------------------------------------------------------------------
  logic [4:0] point_count_q;
  logic [1:0] left_mode_q;
  logic [1:0] right_mode_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= 5'd2;
      left_mode_q   <= pli_pkg::MODE_EXTEND;
      right_mode_q  <= pli_pkg::MODE_EXTEND;
    end else if (cfg_we) begin
      case (paddr[3:2])
        pli_pkg::REG_POINT_COUNT: point_count_q <= pwdata[4:0];
        pli_pkg::REG_LEFT_MODE:   left_mode_q   <= pwdata[1:0];
        pli_pkg::REG_RIGHT_MODE:  right_mode_q  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      pli_pkg::REG_POINT_COUNT: prdata = {27'b0, point_count_q};
      pli_pkg::REG_LEFT_MODE:   prdata = {30'b0, left_mode_q};
      pli_pkg::REG_RIGHT_MODE:  prdata = {30'b0, right_mode_q};
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Breakpoint table: two memories sharing one write address and one read
  // address. Read data is registered, so an address presented in one cycle
  // shows its entry in the next.
  // ---------------------------------------------------------------------------
  logic signed [31:0] in_pts  [MAX_POINTS];
  logic signed [31:0] out_pts [MAX_POINTS];
  logic signed [31:0] rd_in_q, rd_out_q;
  logic [AW-1:0]      rd_addr;
  logic               in_acc;
  logic               load_we;

  assign in_acc  = in_valid_i & ~in_stall_o;
  // A load aimed at a slot beyond the table is dropped.
  assign load_we = in_acc && (in_data_i.command == pli_pkg::CMD_LOAD) &&
                   (32'(in_data_i.point_index) < MAX_POINTS);

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      in_pts[AW'(in_data_i.point_index)]  <= in_data_i.point_in;
      out_pts[AW'(in_data_i.point_index)] <= in_data_i.point_out;
    end
    rd_in_q  <= in_pts[rd_addr];
    rd_out_q <= out_pts[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // Sequencer and datapath registers.
  // ---------------------------------------------------------------------------
  logic [3:0]         state_q, state_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [AW-1:0]      seg_q, seg_d;
  logic [CW-1:0]      cntm1_q, cntm1_d;
  logic signed [31:0] x_q, x_d;
  logic signed [31:0] lo_q, lo_d;
  logic signed [31:0] hi_q, hi_d;
  logic signed [31:0] ylo_q, ylo_d;
  logic signed [31:0] yhi_q, yhi_d;
  logic signed [32:0] num_q, num_d;
  logic signed [32:0] dy_q, dy_d;
  logic signed [32:0] den_q, den_d;
  logic               neg_q, neg_d;
  logic [32:0]        q_q, q_d;
  logic signed [34:0] sum_q, sum_d;
  logic signed [31:0] res_q, res_d;
  logic               fault_q, fault_d;
  logic               out_valid_q, out_valid_d;
  pli_pkg::out_item_t out_q, out_d;

  logic [CW-1:0]      pc_w, cnt_w;
  logic               srch_go;
  logic [34:0]        ylo_ext, q_ext;
  pli_pkg::md_req_t   md_req;
  pli_pkg::md_rsp_t   md_rsp;

  // Effective point count, clamped into 2 .. MAX_POINTS.
  assign pc_w  = CW'(point_count_q);
  assign cnt_w = (pc_w < CntMin) ? CntMin : ((pc_w > CntMax) ? CntMax : pc_w);

  // The walk goes on while the entry just read lies below the sample and the
  // next-to-last breakpoint has not been passed.
  assign srch_go = (CW'(idx_q) < cntm1_q) && (rd_in_q < x_q);

  assign ylo_ext = {{3{ylo_q[31]}}, ylo_q};
  assign q_ext   = {2'b0, q_q};

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    seg_d       = seg_q;
    cntm1_d     = cntm1_q;
    x_d         = x_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    ylo_d       = ylo_q;
    yhi_d       = yhi_q;
    num_d       = num_q;
    dy_d        = dy_q;
    den_d       = den_q;
    neg_d       = neg_q;
    q_d         = q_q;
    sum_d       = sum_q;
    res_d       = res_q;
    fault_d     = fault_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    rd_addr     = idx_q;

    md_req.start = 1'b0;
    md_req.num   = num_q;
    md_req.dy    = dy_q;
    md_req.den   = den_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        rd_addr = AW'(1);
        if (in_acc && (in_data_i.command == pli_pkg::CMD_EVAL)) begin
          x_d     = in_data_i.sample;
          idx_d   = AW'(1);
          cntm1_d = cnt_w - CW'(1);
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (srch_go) begin
          idx_d   = idx_q + AW'(1);
          rd_addr = idx_q + AW'(1);
        end else begin
          // The entry in hand closes the segment; fetch its lower end next.
          hi_d    = rd_in_q;
          yhi_d   = rd_out_q;
          seg_d   = idx_q - AW'(1);
          rd_addr = idx_q - AW'(1);
          state_d = S_RDLO;
        end
      end
      S_RDLO: begin
        lo_d    = rd_in_q;
        ylo_d   = rd_out_q;
        state_d = S_LEFT;
      end
      S_LEFT: begin
        state_d = S_RIGHT;
        if (x_q < lo_q) begin
          if (left_mode_q == pli_pkg::MODE_IDENTITY) begin
            res_d   = x_q;
            fault_d = 1'b0;
            state_d = S_OUT;
          end else if (left_mode_q == pli_pkg::MODE_CLAMP) begin
            x_d = lo_q;
          end
        end
      end
      S_RIGHT: begin
        // This check sees the sample after any left clamp.
        state_d = S_DIFF;
        if (x_q > hi_q) begin
          if (right_mode_q == pli_pkg::MODE_IDENTITY) begin
            res_d   = x_q;
            fault_d = 1'b0;
            state_d = S_OUT;
          end else if (right_mode_q == pli_pkg::MODE_CLAMP) begin
            x_d = hi_q;
          end
        end
      end
      S_DIFF: begin
        den_d = $signed({hi_q[31], hi_q}) - $signed({lo_q[31], lo_q});
        num_d = $signed({x_q[31], x_q}) - $signed({lo_q[31], lo_q});
        dy_d  = $signed({yhi_q[31], yhi_q}) - $signed({ylo_q[31], ylo_q});
        if (hi_q == lo_q) begin
          // A segment of zero width returns its lower output point.
          res_d   = ylo_q;
          fault_d = 1'b1;
          state_d = S_OUT;
        end else begin
          state_d = S_START;
        end
      end
      S_START: begin
        md_req.start = 1'b1;
        neg_d        = num_q[32] ^ dy_q[32] ^ den_q[32];
        state_d      = S_MD;
      end
      S_MD: begin
        if (md_rsp.done) begin
          q_d     = md_rsp.quot;
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        sum_d   = neg_q ? $signed(ylo_ext - q_ext) : $signed(ylo_ext + q_ext);
        state_d = S_SAT;
      end
      S_SAT: begin
        if (sum_q > SumMax) begin
          res_d = 32'sh7FFF_FFFF;
        end else if (sum_q < SumMin) begin
          res_d = 32'sh8000_0000;
        end else begin
          res_d = sum_q[31:0];
        end
        fault_d = 1'b0;
        state_d = S_OUT;
      end
      S_OUT: begin
        // Wait here only while an earlier result is still held by a stall.
        if (!out_valid_q || !out_stall_i) begin
          out_d.result           = res_q;
          out_d.segment          = 4'(seg_q);
          out_d.zero_width_fault = fault_q;
          out_valid_d            = 1'b1;
          state_d                = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    seg_q   <= seg_d;
    cntm1_q <= cntm1_d;
    x_q     <= x_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    ylo_q   <= ylo_d;
    yhi_q   <= yhi_d;
    num_q   <= num_d;
    dy_q    <= dy_d;
    den_q   <= den_d;
    neg_q   <= neg_d;
    q_q     <= q_d;
    sum_q   <= sum_d;
    res_q   <= res_d;
    fault_q <= fault_d;
    out_q   <= out_d;
  end

  // Shared multiply/divide unit: |num*dy| / |den|, rounded and capped.
  pli_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  // Input is taken only when the sequencer is idle; a result waiting in the
  // output register does not hold off the next transaction.
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/pli_checker.sv
// Port-level checker for the piecewise linear interpolator, bound to the top level.
// Depends on pli_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "piecewise_linear_interpolator_top_macros.svh"

module pli_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input pli_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input pli_pkg::out_item_t out_data_o
);

  // An accepted evaluate keeps the input stalled while it is worked on.
  `PLI_ASSERT_NEXT(a_eval_busy, in_valid_i && !in_stall_o && (in_data_i.command == pli_pkg::CMD_EVAL), in_stall_o)

  // A load finishes at once and leaves the input open.
  `PLI_ASSERT_NEXT(a_load_open, in_valid_i && !in_stall_o && (in_data_i.command == pli_pkg::CMD_LOAD), !in_stall_o)

  // A new result only appears at the end of an evaluate.
  `PLI_ASSERT_SAME(a_result_after_work, $rose(out_valid_o), $past(in_stall_o))

  // A stalled result stays valid and unchanged.
  `PLI_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

endmodule

bind piecewise_linear_interpolator_top pli_checker u_pli_checker (.*);
